[src/fat_chain_block_allocator_unit_macros.svh]
// Assertion macros for the block allocator unit.
// Each macro expects clk_i and rst_ni in the scope that uses it.
`ifndef FAT_CHAIN_BLOCK_ALLOCATOR_UNIT_MACROS_SVH
`define FAT_CHAIN_BLOCK_ALLOCATOR_UNIT_MACROS_SVH

// Same-cycle implication.
`define FCBA_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define FCBA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/fcba_pkg.sv]
// Shared constants of the block allocator: command and status codes, field widths.
// No dependencies.
package fcba_pkg;

  localparam int CMD_W  = 2;
  localparam int STAT_W = 2;

  localparam logic [CMD_W-1:0] CMD_ALLOC  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_FREE   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_LOCATE = 2'd2;

  localparam logic [STAT_W-1:0] STAT_OK      = 2'd0;
  localparam logic [STAT_W-1:0] STAT_NOSPACE = 2'd1;
  localparam logic [STAT_W-1:0] STAT_EARLY   = 2'd2;

endpackage

[src/fcba_mem.sv]
// Allocation table storage: one write port, one read port, registered read data.
// No dependencies.
module fcba_mem #(
  parameter int DEPTH  = 1024,
  parameter int WORD_W = 12
) (
  input  logic                     clk_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [WORD_W-1:0]        rd_data_o,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [WORD_W-1:0]        wr_data_i
);

  logic [WORD_W-1:0] mem_q [DEPTH];
  logic [WORD_W-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

[src/fcba_ctrl.sv]
// Command sequencer: clears the table after reset, then runs allocate, free and
// locate walks over the table memory. Depends on fcba_pkg and the macro header.
`include "fat_chain_block_allocator_unit_macros.svh"

module fcba_ctrl
  import fcba_pkg::*;
#(
  parameter int NUM_BLOCKS = 1024
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [CMD_W-1:0]                    in_cmd_i,
  input  logic [$clog2(NUM_BLOCKS+1)-1:0]     in_start_i,
  input  logic [$clog2(NUM_BLOCKS+1)-1:0]     in_count_i,
  output logic                                res_valid_o,
  input  logic                                res_ready_i,
  output logic [$clog2(NUM_BLOCKS+1)-1:0]     res_block_o,
  output logic [$clog2(NUM_BLOCKS+1)-1:0]     res_freed_o,
  output logic [STAT_W-1:0]                   res_status_o,
  output logic                                rd_en_o,
  output logic [$clog2(NUM_BLOCKS)-1:0]       rd_addr_o,
  input  logic [$clog2(NUM_BLOCKS+1):0]       rd_data_i,
  output logic                                wr_en_o,
  output logic [$clog2(NUM_BLOCKS)-1:0]       wr_addr_o,
  output logic [$clog2(NUM_BLOCKS+1):0]       wr_data_o
);

  localparam int AW = $clog2(NUM_BLOCKS);
  localparam int BW = $clog2(NUM_BLOCKS + 1);
  localparam logic [BW-1:0] NULL_BLK  = BW'(NUM_BLOCKS);
  localparam logic [AW-1:0] LAST_ADDR = AW'(NUM_BLOCKS - 1);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_ALLOC = 3'd2;
  localparam logic [2:0] S_AFIN  = 3'd3;
  localparam logic [2:0] S_FREE  = 3'd4;
  localparam logic [2:0] S_LOC   = 3'd5;
  localparam logic [2:0] S_DONE  = 3'd6;

  logic [2:0]        state_q, state_d;
  logic [AW-1:0]     cur_q, cur_d;
  logic [AW-1:0]     prev_q, prev_d;
  logic [AW-1:0]     first_q, first_d;
  logic [BW-1:0]     ctr_q, ctr_d;
  logic [BW-1:0]     cnt_q, cnt_d;
  logic [BW-1:0]     freed_q, freed_d;
  logic [BW-1:0]     free_count_q, free_count_d;
  logic [BW-1:0]     res_block_q, res_block_d;
  logic [BW-1:0]     res_freed_q, res_freed_d;
  logic [STAT_W-1:0] res_status_q, res_status_d;

  logic          rd_used;
  logic [BW-1:0] rd_link;
  logic [BW-1:0] ctr_inc;
  logic [BW-1:0] freed_nxt;
  logic [AW-1:0] cur_inc;

  assign rd_used   = rd_data_i[BW];
  assign rd_link   = rd_data_i[BW-1:0];
  assign ctr_inc   = ctr_q + BW'(1);
  assign freed_nxt = freed_q + BW'(rd_used);
  assign cur_inc   = cur_q + AW'(1);

  always_comb begin
    state_d      = state_q;
    cur_d        = cur_q;
    prev_d       = prev_q;
    first_d      = first_q;
    ctr_d        = ctr_q;
    cnt_d        = cnt_q;
    freed_d      = freed_q;
    free_count_d = free_count_q;
    res_block_d  = res_block_q;
    res_freed_d  = res_freed_q;
    res_status_d = res_status_q;
    rd_en_o      = 1'b0;
    rd_addr_o    = cur_q;
    wr_en_o      = 1'b0;
    wr_addr_o    = cur_q;
    wr_data_o    = {1'b0, NULL_BLK};

    case (state_q)
      S_CLEAR: begin
        wr_en_o = 1'b1;
        cur_d   = cur_inc;
        if (cur_q == LAST_ADDR) begin
          state_d = S_IDLE;
        end
      end

      S_IDLE: begin
        if (in_valid_i) begin
          ctr_d       = '0;
          freed_d     = '0;
          cnt_d       = in_count_i;
          res_block_d = NULL_BLK;
          res_freed_d = '0;
          res_status_d = STAT_OK;
          state_d     = S_DONE;
          case (in_cmd_i)
            CMD_ALLOC: begin
              if (in_count_i == '0) begin
                state_d = S_DONE;
              end else if (in_count_i > free_count_q) begin
                res_status_d = STAT_NOSPACE;
              end else begin
                // the scan starts at block zero; reserve the whole count up front
                rd_en_o      = 1'b1;
                rd_addr_o    = '0;
                cur_d        = '0;
                free_count_d = free_count_q - in_count_i;
                state_d      = S_ALLOC;
              end
            end
            CMD_FREE: begin
              if (in_start_i < NULL_BLK) begin
                rd_en_o   = 1'b1;
                rd_addr_o = in_start_i[AW-1:0];
                cur_d     = in_start_i[AW-1:0];
                state_d   = S_FREE;
              end
            end
            CMD_LOCATE: begin
              if (in_start_i >= NULL_BLK) begin
                res_status_d = STAT_EARLY;
              end else if (in_count_i == '0) begin
                res_block_d = in_start_i;
              end else begin
                rd_en_o   = 1'b1;
                rd_addr_o = in_start_i[AW-1:0];
                cur_d     = in_start_i[AW-1:0];
                state_d   = S_LOC;
              end
            end
            default: begin
              state_d = S_DONE;
            end
          endcase
        end
      end

      S_ALLOC: begin
        if (!rd_used) begin
          ctr_d  = ctr_inc;
          prev_d = cur_q;
          if (ctr_q != '0) begin
            // link the previous block of the chain to this one
            wr_en_o   = 1'b1;
            wr_addr_o = prev_q;
            wr_data_o = {1'b1, BW'(cur_q)};
          end else begin
            first_d = cur_q;
          end
        end
        if (!rd_used && ctr_inc == cnt_q) begin
          state_d = S_AFIN;
        end else begin
          rd_en_o   = 1'b1;
          rd_addr_o = cur_inc;
          cur_d     = cur_inc;
        end
      end

      S_AFIN: begin
        // close the chain at its last block
        wr_en_o      = 1'b1;
        wr_addr_o    = prev_q;
        wr_data_o    = {1'b1, NULL_BLK};
        res_block_d  = BW'(first_q);
        res_freed_d  = '0;
        res_status_d = STAT_OK;
        state_d      = S_DONE;
      end

      S_FREE: begin
        wr_en_o      = 1'b1;
        wr_addr_o    = cur_q;
        freed_d      = freed_nxt;
        free_count_d = free_count_q + BW'(rd_used);
        ctr_d        = ctr_inc;
        if (rd_link >= NULL_BLK || ctr_inc == NULL_BLK) begin
          res_block_d  = NULL_BLK;
          res_freed_d  = freed_nxt;
          res_status_d = STAT_OK;
          state_d      = S_DONE;
        end else begin
          rd_en_o   = 1'b1;
          rd_addr_o = rd_link[AW-1:0];
          cur_d     = rd_link[AW-1:0];
        end
      end

      S_LOC: begin
        ctr_d = ctr_inc;
        if (rd_link >= NULL_BLK) begin
          res_block_d  = NULL_BLK;
          res_status_d = STAT_EARLY;
          state_d      = S_DONE;
        end else if (ctr_inc == cnt_q) begin
          res_block_d  = rd_link;
          res_status_d = STAT_OK;
          state_d      = S_DONE;
        end else begin
          rd_en_o   = 1'b1;
          rd_addr_o = rd_link[AW-1:0];
          cur_d     = rd_link[AW-1:0];
        end
      end

      S_DONE: begin
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_CLEAR;
      cur_q        <= '0;
      free_count_q <= NULL_BLK;
    end else begin
      state_q      <= state_d;
      cur_q        <= cur_d;
      free_count_q <= free_count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    prev_q       <= prev_d;
    first_q      <= first_d;
    ctr_q        <= ctr_d;
    cnt_q        <= cnt_d;
    freed_q      <= freed_d;
    res_block_q  <= res_block_d;
    res_freed_q  <= res_freed_d;
    res_status_q <= res_status_d;
  end

  assign in_ready_o   = (state_q == S_IDLE);
  assign res_valid_o  = (state_q == S_DONE);
  assign res_block_o  = res_block_q;
  assign res_freed_o  = res_freed_q;
  assign res_status_o = res_status_q;

  `FCBA_ASSERT_IMPL(a_no_rw_collide, rd_en_o && wr_en_o, rd_addr_o != wr_addr_o, "table read and write hit the same entry")
  `FCBA_ASSERT_IMPL(a_accept_quiet, in_valid_i && in_ready_o, !wr_en_o, "table write pending while a word is accepted")
  `FCBA_ASSERT_IMPL(a_free_count_range, state_q != S_CLEAR, free_count_q <= NULL_BLK, "free count above table size")
  `FCBA_ASSERT_NEXT(a_res_hold, res_valid_o && !res_ready_i, res_valid_o && $stable(res_block_o), "result dropped while stalled")

endmodule

[src/fat_chain_block_allocator_unit.sv]
// Top level of the block-chain allocation table: sequencer, table memory, output register.
// Depends on fcba_pkg, fcba_mem and fcba_ctrl.
//
//  channel  | dir | handshake                     | tdata fields, lowest bit up
//  ---------+-----+-------------------------------+------------------------------------
//  s_axis   | in  | s_axis_tvalid / s_axis_tready | cmd, start_block, count
//  m_axis   | out | m_axis_tvalid / m_axis_tready | block, freed, status
//
// After reset the table is cleared one entry a cycle, with s_axis_tready low throughout.
// Allocate scans up from block zero; the scan reads one entry a cycle through the single
// read port. Free walks the chain and locate hops along it, each hop one dependent memory
// read. Rejected and trivial commands need no walk. The result then goes to the output
// register and the sequencer goes idle; it stalls while the register is full and not drained.
// The output register lets a new word be accepted while a result waits on m_axis_tready.
module fat_chain_block_allocator_unit
  import fcba_pkg::*;
#(
  parameter int NUM_BLOCKS = 1024
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  // cmd, start_block, count; zero padding above
  input  logic [((CMD_W + 2 * $clog2(NUM_BLOCKS + 1) + 7) / 8) * 8 - 1:0] s_axis_tdata,
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  // block, freed, status; zero padding above
  output logic [((STAT_W + 2 * $clog2(NUM_BLOCKS + 1) + 7) / 8) * 8 - 1:0] m_axis_tdata
);

  localparam int AW     = $clog2(NUM_BLOCKS);
  localparam int BW     = $clog2(NUM_BLOCKS + 1);
  localparam int WORD_W = BW + 1;
  localparam int OUT_W  = ((STAT_W + 2 * BW + 7) / 8) * 8;

  // unpack the input word
  logic [CMD_W-1:0] in_cmd;
  logic [BW-1:0]    in_start;
  logic [BW-1:0]    in_count;

  assign in_cmd   = s_axis_tdata[CMD_W-1:0];
  assign in_start = s_axis_tdata[CMD_W+BW-1:CMD_W];
  assign in_count = s_axis_tdata[CMD_W+2*BW-1:CMD_W+BW];

  // sequencer result side
  logic              res_valid;
  logic              res_ready;
  logic [BW-1:0]     res_block;
  logic [BW-1:0]     res_freed;
  logic [STAT_W-1:0] res_status;

  // table memory ports
  logic              rd_en;
  logic [AW-1:0]     rd_addr;
  logic [WORD_W-1:0] rd_data;
  logic              wr_en;
  logic [AW-1:0]     wr_addr;
  logic [WORD_W-1:0] wr_data;

  fcba_ctrl #(
    .NUM_BLOCKS (NUM_BLOCKS)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .in_cmd_i     (in_cmd),
    .in_start_i   (in_start),
    .in_count_i   (in_count),
    .res_valid_o  (res_valid),
    .res_ready_i  (res_ready),
    .res_block_o  (res_block),
    .res_freed_o  (res_freed),
    .res_status_o (res_status),
    .rd_en_o      (rd_en),
    .rd_addr_o    (rd_addr),
    .rd_data_i    (rd_data),
    .wr_en_o      (wr_en),
    .wr_addr_o    (wr_addr),
    .wr_data_o    (wr_data)
  );

  // each entry holds the used bit above the next-block link
  fcba_mem #(
    .DEPTH  (NUM_BLOCKS),
    .WORD_W (WORD_W)
  ) u_mem (
    .clk_i     (clk_i),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data)
  );

  // output register: take a result whenever the slot is empty or being drained
  logic              out_valid_q, out_valid_d;
  logic [BW-1:0]     out_block_q;
  logic [BW-1:0]     out_freed_q;
  logic [STAT_W-1:0] out_status_q;

  assign res_ready = !out_valid_q || m_axis_tready;

  always_comb begin
    out_valid_d = out_valid_q;
    if (res_valid && res_ready) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // hold the payload until a new result is taken
  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_block_q  <= res_block;
      out_freed_q  <= res_freed;
      out_status_q <= res_status;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OUT_W'({out_status_q, out_freed_q, out_block_q});

endmodule

[tb/sv/tb_fat_chain_block_allocator_unit.sv]
// Self-checking testbench for fat_chain_block_allocator_unit: directed rows, then random chains.
// Depends on fcba_pkg and the unit RTL; keeps its own model of the allocation table.
module tb_fat_chain_block_allocator_unit;
  import fcba_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_BLOCKS = 1024;
  localparam int BLK_W      = $clog2(NUM_BLOCKS + 1);
  localparam int IN_W       = ((CMD_W + 2 * BLK_W + 7) / 8) * 8;
  localparam int OUT_W      = ((STAT_W + 2 * BLK_W + 7) / 8) * 8;

  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam logic [BLK_W-1:0] NULL_BLK   = BLK_W'(NUM_BLOCKS);
  localparam logic [BLK_W-1:0] FIELD_MAX  = '1;

  localparam int  RANDOM_ITEMS = 555;
  localparam int  DRAIN_CYCLES = 16;
  // Reset clearing pass plus every word at its slowest walk, sender gap and receiver stall,
  // taken several times over.
  localparam longint CYCLE_LIMIT = 4_000_000;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic [BLK_W-1:0] start;
    logic [BLK_W-1:0] count;
  } fat_cmd_t;

  typedef struct packed {
    logic [BLK_W-1:0]  block;
    logic [BLK_W-1:0]  freed;
    logic [STAT_W-1:0] status;
  } fat_res_t;

  // One row of the directed part; res is used only where typed is set.
  typedef struct packed {
    fat_cmd_t op;
    bit       typed;
    fat_res_t res;
  } dir_row_t;

  localparam fat_res_t PRED_ONLY = '0;

  logic             clk_i = 1'b0;
  logic             rst_ni;
  logic             s_axis_tvalid;
  logic             s_axis_tready;
  logic [IN_W-1:0]  s_axis_tdata;   // cmd, start_block, count
  logic             m_axis_tvalid;
  logic             m_axis_tready;
  logic [OUT_W-1:0] m_axis_tdata;   // block, freed, status

  // Model copy of the table: used bit, next link and free count.
  bit               blk_used [NUM_BLOCKS];
  logic [BLK_W-1:0] blk_next [NUM_BLOCKS];
  int               free_blocks;

  fat_res_t         pending_results [$];  // results owed by the unit, oldest first
  logic [BLK_W-1:0] chain_heads [$];      // first blocks of allocated chains, may go stale
  int               err_count;
  int               calm_items;           // words left to send back to back
  longint           cycles;

  fat_chain_block_allocator_unit #(
    .NUM_BLOCKS(NUM_BLOCKS)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // Directed part: field extremes, every command, and the corner cases. A full-table
  // allocation from reset gives the chain 0..1023, so its walks can be read off directly.
  dir_row_t dir_rows [0:25] = '{
    // zero-length allocation
    '{'{CMD_ALLOC,  11'd0,    11'd0},    1'b1, '{NULL_BLK, 11'd0, STAT_OK}},
    // larger than the free count, and the widest count
    '{'{CMD_ALLOC,  11'd0,    11'd1025}, 1'b1, '{NULL_BLK, 11'd0, STAT_NOSPACE}},
    '{'{CMD_ALLOC,  FIELD_MAX, FIELD_MAX}, 1'b1, '{NULL_BLK, 11'd0, STAT_NOSPACE}},
    // locate and free with no start block
    '{'{CMD_LOCATE, NULL_BLK, 11'd0},    1'b1, '{NULL_BLK, 11'd0, STAT_EARLY}},
    '{'{CMD_LOCATE, FIELD_MAX, FIELD_MAX}, 1'b1, '{NULL_BLK, 11'd0, STAT_EARLY}},
    '{'{CMD_FREE,   NULL_BLK, 11'd0},    1'b1, '{NULL_BLK, 11'd0, STAT_OK}},
    '{'{CMD_FREE,   FIELD_MAX, FIELD_MAX}, 1'b1, '{NULL_BLK, 11'd0, STAT_OK}},
    // unused command value
    '{'{CMD_UNUSED, FIELD_MAX, FIELD_MAX}, 1'b1, '{NULL_BLK, 11'd0, STAT_OK}},
    // take the whole table, then one more
    '{'{CMD_ALLOC,  11'd0,    11'd1024}, 1'b1, '{11'd0,    11'd0, STAT_OK}},
    '{'{CMD_ALLOC,  11'd0,    11'd1},    1'b1, '{NULL_BLK, 11'd0, STAT_NOSPACE}},
    // walk the full chain: last block, one hop past, zero hops, widest hop count
    '{'{CMD_LOCATE, 11'd0,    11'd1023}, 1'b1, '{11'd1023, 11'd0, STAT_OK}},
    '{'{CMD_LOCATE, 11'd0,    11'd1024}, 1'b1, '{NULL_BLK, 11'd0, STAT_EARLY}},
    '{'{CMD_LOCATE, 11'd1023, 11'd0},    1'b1, '{11'd1023, 11'd0, STAT_OK}},
    '{'{CMD_LOCATE, 11'd0,    FIELD_MAX}, 1'b1, '{NULL_BLK, 11'd0, STAT_EARLY}},
    // release everything, then free an already free block
    '{'{CMD_FREE,   11'd0,    11'd0},    1'b1, '{NULL_BLK, 11'd1024, STAT_OK}},
    '{'{CMD_FREE,   11'd0,    11'd0},    1'b1, '{NULL_BLK, 11'd0, STAT_OK}},
    '{'{CMD_LOCATE, 11'd5,    11'd1},    1'b1, '{NULL_BLK, 11'd0, STAT_EARLY}},
    '{'{CMD_LOCATE, 11'd5,    11'd0},    1'b0, PRED_ONLY},
    // fragment the table and reuse the holes
    '{'{CMD_ALLOC,  11'd0,    11'd3},    1'b0, PRED_ONLY},
    '{'{CMD_ALLOC,  11'd0,    11'd2},    1'b0, PRED_ONLY},
    '{'{CMD_FREE,   11'd1,    11'd0},    1'b0, PRED_ONLY},
    '{'{CMD_ALLOC,  11'd0,    11'd5},    1'b0, PRED_ONLY},
    '{'{CMD_LOCATE, 11'd1,    11'd4},    1'b0, PRED_ONLY},
    '{'{CMD_FREE,   11'd5,    11'd0},    1'b0, PRED_ONLY},
    // the walk stops at a block that is already free
    '{'{CMD_FREE,   11'd1,    11'd0},    1'b0, PRED_ONLY},
    '{'{CMD_FREE,   11'd0,    11'd0},    1'b0, PRED_ONLY}
  };

  // Clock: 10 ns period.
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Apply one command to the model table and return the result it owes.
  task automatic fat_apply(input fat_cmd_t c, output fat_res_t r);
    int i;
    int b;
    int prev;
    int cur;
    int nxt;
    int nfree;
    r = '{NULL_BLK, '0, STAT_OK};
    case (c.cmd)
      CMD_ALLOC: begin
        if (c.count > free_blocks) begin
          r.status = STAT_NOSPACE;
        end else begin
          // Lowest free block each time: one ascending scan suffices.
          b = 0;
          prev = -1;
          for (i = 0; i < c.count; i++) begin
            while (blk_used[b]) b++;
            if (prev >= 0) blk_next[prev] = BLK_W'(b);
            else r.block = BLK_W'(b);
            blk_used[b] = 1'b1;
            blk_next[b] = NULL_BLK;
            free_blocks--;
            prev = b;
          end
        end
      end
      CMD_FREE: begin
        cur = c.start;
        nfree = 0;
        for (i = 0; i < NUM_BLOCKS && cur < NUM_BLOCKS; i++) begin
          nxt = blk_next[cur];
          if (blk_used[cur]) begin
            blk_used[cur] = 1'b0;
            nfree++;
            free_blocks++;
          end
          blk_next[cur] = NULL_BLK;
          cur = nxt;
        end
        r.freed = BLK_W'(nfree);
      end
      CMD_LOCATE: begin
        cur = c.start;
        if (cur >= NUM_BLOCKS) begin
          r.status = STAT_EARLY;
        end else begin
          for (i = 0; i < c.count && r.status == STAT_OK; i++) begin
            cur = blk_next[cur];
            if (cur >= NUM_BLOCKS) r.status = STAT_EARLY;
          end
          if (r.status == STAT_OK) r.block = BLK_W'(cur);
        end
      end
      default: ;
    endcase
  endtask

  // Drive one word; entered and left at a falling edge.
  task automatic send_word(input fat_cmd_t c);
    int roll;
    int gap;
    gap = 0;
    if (calm_items > 0) begin
      calm_items--;
    end else begin
      roll = $urandom_range(0, 99);
      if (roll < 5) calm_items = $urandom_range(20, 80);
      else if (roll < 55) gap = 0;
      else if (roll < 92) gap = $urandom_range(1, 3);
      else gap = $urandom_range(8, 40);
    end
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= IN_W'({c.count, c.start, c.cmd});
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
  endtask

  // Predict, record the chain head if one was allocated, and send.
  task automatic issue_word(input fat_cmd_t c, input bit typed, input fat_res_t typed_res);
    fat_res_t r;
    fat_apply(c, r);
    if (c.cmd == CMD_ALLOC && r.status == STAT_OK && r.block != NULL_BLK)
      chain_heads.push_back(r.block);
    pending_results.push_back(typed ? typed_res : r);
    send_word(c);
  endtask

  // Mostly well-formed traffic on live chains, with some noise and ignored commands.
  task automatic pick_random(output fat_cmd_t c);
    int roll;
    int k;
    int len;
    int cur;
    int hops;
    c = '0;
    k = 0;
    len = 0;
    roll = $urandom_range(0, 99);
    // Lean on frees when the table runs low.
    if (free_blocks < 200 && roll < 40) roll += 40;
    if (chain_heads.size() == 0 && roll >= 40 && roll < 90) roll = 0;
    if (roll >= 40 && roll < 90) begin
      k = $urandom_range(0, chain_heads.size() - 1);
      cur = chain_heads[k];
      while (cur < NUM_BLOCKS && blk_next[cur] < NUM_BLOCKS && len < NUM_BLOCKS) begin
        cur = blk_next[cur];
        len++;
      end
    end
    c.count = BLK_W'($urandom_range(0, 2047));
    if (roll < 40) begin
      c.cmd = CMD_ALLOC;
      c.start = BLK_W'($urandom_range(0, 2047));
      hops = $urandom_range(0, 99);
      if (hops < 75) c.count = BLK_W'($urandom_range(1, 8));
      else if (hops < 95) c.count = BLK_W'($urandom_range(9, 64));
      else c.count = BLK_W'($urandom_range(65, 1100));
    end else if (roll < 65) begin
      // Release a whole chain.
      c.cmd = CMD_FREE;
      c.start = chain_heads[k];
      chain_heads.delete(k);
    end else if (roll < 72) begin
      // Cut a chain short: release from somewhere inside it.
      c.cmd = CMD_FREE;
      cur = chain_heads[k];
      hops = $urandom_range(0, len + 1);
      for (int h = 0; h < hops && cur < NUM_BLOCKS; h++) cur = blk_next[cur];
      c.start = BLK_W'(cur);
    end else if (roll < 90) begin
      c.cmd = CMD_LOCATE;
      c.start = chain_heads[k];
      c.count = BLK_W'($urandom_range(0, len + 1));
    end else if (roll < 96) begin
      c.cmd = CMD_W'($urandom_range(0, 2));
      c.start = BLK_W'($urandom_range(0, 2047));
    end else begin
      c.cmd = CMD_UNUSED;
      c.start = BLK_W'($urandom_range(0, 2047));
    end
  endtask

  // Receiver: ready with short and long stalls, and calm stretches.
  initial begin : ready_gen
    int calm_left;
    int stall_left;
    int roll;
    m_axis_tready = 1'b0;
    calm_left = 0;
    stall_left = 0;
    forever begin
      @(negedge clk_i);
      if (calm_left > 0) begin
        calm_left--;
        m_axis_tready <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else begin
        roll = $urandom_range(0, 99);
        if (roll < 5) begin
          calm_left = $urandom_range(50, 300);
          m_axis_tready <= 1'b1;
        end else if (roll < 30) begin
          stall_left = (roll < 27) ? $urandom_range(0, 2) : $urandom_range(20, 60);
          m_axis_tready <= 1'b0;
        end else begin
          m_axis_tready <= 1'b1;
        end
      end
    end
  end

  // Check each accepted word against the oldest owed result.
  always @(posedge clk_i) begin
    fat_res_t got;
    fat_res_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.block  = m_axis_tdata[BLK_W-1:0];
      got.freed  = m_axis_tdata[2*BLK_W-1:BLK_W];
      got.status = m_axis_tdata[2*BLK_W +: STAT_W];
      if (pending_results.size() == 0) begin
        $error("unexpected result word: block %0d freed %0d status %0d",
               got.block, got.freed, got.status);
        err_count++;
      end else begin
        want = pending_results.pop_front();
        if (got.block !== want.block) begin
          $error("block: expected %0d, got %0d", want.block, got.block);
          err_count++;
        end
        if (got.freed !== want.freed) begin
          $error("freed: expected %0d, got %0d", want.freed, got.freed);
          err_count++;
        end
        if (got.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, got.status);
          err_count++;
        end
      end
    end
  end

  // Watchdog: stop a hung run.
  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin : main
    fat_cmd_t c;
    int issued;
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    err_count = 0;
    calm_items = 0;
    cycles = 0;
    issued = 0;
    for (int i = 0; i < NUM_BLOCKS; i++) begin
      blk_used[i] = 1'b0;
      blk_next[i] = NULL_BLK;
    end
    free_blocks = NUM_BLOCKS;

    // Hold reset, then release it at a falling edge; the clearing pass that follows shows as tready low.
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (dir_rows[i]) issue_word(dir_rows[i].op, dir_rows[i].typed, dir_rows[i].res);

    // Ignored commands do not advance the count.
    while (issued < RANDOM_ITEMS) begin
      pick_random(c);
      issue_word(c, 1'b0, PRED_ONLY);
      if (c.cmd != CMD_UNUSED) issued++;
    end
    s_axis_tvalid <= 1'b0;

    // Drain owed results, then watch for stray words.
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

[files.f]
+incdir+src
src/fcba_pkg.sv
src/fcba_mem.sv
src/fcba_ctrl.sv
src/fat_chain_block_allocator_unit.sv
tb/sv/tb_fat_chain_block_allocator_unit.sv
